### design/pic_pkg.sv
// shared types and constants for the point in polygon crossing test
// no dependencies
package pic_pkg;

    localparam int MAX_VERTICES_DEF = 16;
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_TEST  = 1'b1;

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
    } t_vtx;

    typedef struct packed {
        logic        en;
        logic [3:0]  slot;
        t_vtx        v;
    } t_wr;

    typedef struct packed {
        logic               vld;
        logic signed [15:0] tx;
        logic signed [15:0] ty;
        t_vtx               prev;
        logic               parity;
    } t_token;

endpackage

### design/pic_cell.sv
// one vertex cell: holds a vertex and tests the edge from the previous vertex
// depends on pic_pkg
module pic_cell #(
    parameter int IDX = 0,
    parameter int NW  = 5
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  pic_pkg::t_wr    i_wr,
    input  logic [NW-1:0]   i_n,
    input  pic_pkg::t_token i_tok,
    output pic_pkg::t_token o_tok,
    output pic_pkg::t_vtx   o_vtx
);

    pic_pkg::t_vtx   r_vtx;
    pic_pkg::t_token r_a_tok, n_a_tok;
    pic_pkg::t_token r_b_tok, n_b_tok;
    logic signed [34:0] r_p, r_ad, n_p, n_ad;
    logic signed [17:0] r_d, n_d;
    logic               r_str, n_str;

    logic signed [16:0] dx, dyt, d, a;
    logic signed [17:0] dxs;
    logic               flip, active;
    logic signed [35:0] rem;
    logic               cond;

    always_ff @(posedge i_clk) begin
        if (i_wr.en && (int'(i_wr.slot) == IDX)) begin
            r_vtx <= i_wr.v;
        end
    end

    always_comb begin
        active = (int'(i_n) > IDX);
        dx  = {i_tok.prev.x[15], i_tok.prev.x} - {r_vtx.x[15], r_vtx.x};
        dyt = {i_tok.ty[15], i_tok.ty} - {r_vtx.y[15], r_vtx.y};
        d   = {i_tok.prev.y[15], i_tok.prev.y} - {r_vtx.y[15], r_vtx.y};
        a   = {i_tok.tx[15], i_tok.tx} - {r_vtx.x[15], r_vtx.x};
        flip = d[16];
        n_d  = flip ? -{d[16], d} : {d[16], d};
        dxs  = flip ? -{dx[16], dx} : {dx[16], dx};
        n_p  = dxs * dyt;
        n_ad = a * n_d;
        n_str = active && ((r_vtx.y > i_tok.ty) != (i_tok.prev.y > i_tok.ty));
        n_a_tok = i_tok;
        n_a_tok.prev = r_vtx;
        // trunc(p/d) > a, with d made positive
        rem  = {r_p[34], r_p} - {r_ad[34], r_ad};
        cond = r_p[34] ? (rem > 36'sd0) : (rem >= $signed({{18{r_d[17]}}, r_d}));
        n_b_tok = r_a_tok;
        n_b_tok.parity = r_a_tok.parity ^ (r_str & cond);
    end

    always_ff @(posedge i_clk) begin
        r_p     <= n_p;
        r_ad    <= n_ad;
        r_d     <= n_d;
        r_str   <= n_str;
        if (!i_rst_n) begin
            r_a_tok <= '0;
            r_b_tok <= '0;
        end else begin
            r_a_tok <= n_a_tok;
            r_b_tok <= n_b_tok;
        end
    end

    assign o_tok = r_b_tok;
    assign o_vtx = r_vtx;

endmodule

### design/point_in_polygon_crossing_test.sv
// top level: vertex cells chained into a query pipeline, each cell registering the token in its a and b stages
// o_valid comes once the token of an accepted test request has passed through every cell
// busy for the whole walk, so no new request is accepted until the last test's result is out
// a vertex write is stored in its cell's register and does not set busy; results cannot be stalled
// synchronous active low reset clears control and count
// depends on pic_pkg and pic_cell
module point_in_polygon_crossing_test #(
    parameter int MAX_VERTICES = pic_pkg::MAX_VERTICES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    output logic               o_busy,
    input  logic               i_operation,
    input  logic [3:0]         i_vertex_slot,
    input  logic signed [15:0] i_x_coord,
    input  logic signed [15:0] i_y_coord,
    input  logic               i_cfg_we,
    input  logic [4:0]         i_cfg_wdata,
    output logic               o_valid,
    output logic               o_inside_res
);

    localparam int CW = $clog2(MAX_VERTICES + 1);
    localparam int NW = (CW > 5) ? CW : 5;
    localparam int IW = $clog2(MAX_VERTICES);

    logic [4:0]      r_count;
    logic            r_busy, r_ok;
    logic [NW-1:0]   n_eff, last;
    logic            accept;
    pic_pkg::t_wr    wr;
    pic_pkg::t_token tok [MAX_VERTICES+1];
    pic_pkg::t_vtx   vtx [MAX_VERTICES];

    always_comb begin
        n_eff = (NW'(r_count) > NW'(MAX_VERTICES)) ? NW'(MAX_VERTICES) : NW'(r_count);
        last  = (n_eff == '0) ? '0 : n_eff - NW'(1);
        accept = i_start && !r_busy;
        wr.en   = accept && (i_operation == pic_pkg::OP_WRITE);
        wr.slot = i_vertex_slot;
        wr.v.x  = i_x_coord;
        wr.v.y  = i_y_coord;
        tok[0].vld    = accept && (i_operation == pic_pkg::OP_TEST);
        tok[0].tx     = i_x_coord;
        tok[0].ty     = i_y_coord;
        tok[0].prev   = vtx[last[IW-1:0]];
        tok[0].parity = 1'b0;
    end

    for (genvar k = 0; k < MAX_VERTICES; k++) begin : g_cell
        pic_cell #(.IDX(k), .NW(NW)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_wr    (wr),
            .i_n     (n_eff),
            .i_tok   (tok[k]),
            .o_tok   (tok[k+1]),
            .o_vtx   (vtx[k])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_busy  <= 1'b0;
            r_ok    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_count <= i_cfg_wdata;
            end
            if (tok[0].vld) begin
                r_busy <= 1'b1;
                r_ok   <= (n_eff >= NW'(3));
            end else if (tok[MAX_VERTICES].vld) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_busy       = r_busy;
    assign o_valid      = tok[MAX_VERTICES].vld;
    assign o_inside_res = tok[MAX_VERTICES].parity & r_ok;

`ifndef SYNTH
    a_test_sets_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy && i_operation == pic_pkg::OP_TEST) |=> o_busy)
        else $error("busy not set after test request");
    a_write_no_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy && i_operation == pic_pkg::OP_WRITE) |=> !o_busy)
        else $error("busy set after write request");
    a_result_when_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_busy)
        else $error("result without a test in flight");
    a_busy_drops_on_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_busy)
        else $error("busy held after result");
`endif

endmodule
